/* design/hdca_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdca_pkg: shared constants and types of the hash dedup cluster assign unit
// Murmur3 constants, register indexes, field widths and the control states.
// ----------------------------------------------------------------------------
package hdca_pkg;

  localparam int unsigned TABLE_SLOTS_DEF = 4096;
  localparam int unsigned KEY_BYTES_DEF   = 4;

  localparam int unsigned KEY_IN_W  = 64;
  localparam int unsigned SLOTS_W   = 13;
  localparam int unsigned CL_W      = 12;
  localparam int unsigned CNT_W     = 13;

  localparam logic [SLOTS_W-1:0] SLOTS_RESET = 13'd4096;
  localparam logic [CNT_W-1:0]   COUNT_MAX   = 13'h1fff;

  // register indexes on the config port
  localparam logic CFG_HASH_SEED    = 1'b0;
  localparam logic CFG_SLOTS_IN_USE = 1'b1;

  localparam logic [31:0] MM_C1  = 32'hcc9e2d51;
  localparam logic [31:0] MM_C2  = 32'h1b873593;
  localparam logic [31:0] MM_F1  = 32'h85ebca6b;
  localparam logic [31:0] MM_F2  = 32'hc2b2ae35;
  localparam logic [31:0] MM_ADD = 32'he6546b64;

  typedef enum logic [8:0] {
    S_CLR  = 9'b000000001,
    S_IDLE = 9'b000000010,
    S_HASH = 9'b000000100,
    S_FIN  = 9'b000001000,
    S_DIV  = 9'b000010000,
    S_PRD  = 9'b000100000,
    S_PCHK = 9'b001000000,
    S_CRD  = 9'b010000000,
    S_OUT  = 9'b100000000
  } state_t;

endpackage

/* design/hash_dedup_cluster_assign_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hash_dedup_cluster_assign_unit: key deduplication into clusters
// Murmur3 hash, modulo by the slots in use, linear probing of a slot table.
// ----------------------------------------------------------------------------
// One key is processed at a time. An item goes through accept, the murmur mix
// of each 32-bit key word (one shared 32x32 multiplier), the final mix, the
// modulo (4 dividend bits per cycle), then per probed slot a synchronous slot
// memory read followed by a compare, on a hit an update of the member count
// memory, and last the load of the output register.
// After reset the slot table is cleared, one entry per cycle, before the
// first word is taken; config writes are taken meanwhile.
// A finished result waits in the output register while the next key is
// already accepted.
module hash_dedup_cluster_assign_unit
  import hdca_pkg::*;
#(
  parameter int unsigned TABLE_SLOTS = TABLE_SLOTS_DEF,
  parameter int unsigned KEY_BYTES   = KEY_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic                cfg_idx,
  input  logic [31:0]         cfg_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [KEY_IN_W-1:0] in_key,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [CL_W-1:0]     out_cluster_id,
  output logic                out_is_new,
  output logic [CNT_W-1:0]    out_cluster_size,
  output logic                out_table_full
);

  localparam int unsigned SW    = (TABLE_SLOTS > 2) ? $clog2(TABLE_SLOTS) : 1;
  localparam int unsigned KEY_W = 8 * KEY_BYTES;
  localparam int unsigned NBLK  = KEY_BYTES / 4;
  localparam int unsigned NW    = (KEY_BYTES + 3) / 4;
  localparam int unsigned SE_W  = 1 + KEY_W + SW;

  // configuration
  logic [31:0]        seed_r;
  logic [SLOTS_W-1:0] slots_r;
  logic [SLOTS_W-1:0] eff;

  // control
  state_t             state_r, state_nxt;
  logic [SW-1:0]      clr_r, clr_nxt;
  logic [CNT_W-1:0]   ncl_r, ncl_nxt;
  logic [1:0]         hstep_r, hstep_nxt;
  logic               word_r, word_nxt;
  logic [2:0]         dcnt_r, dcnt_nxt;
  logic [SLOTS_W-1:0] pos_r, pos_nxt;
  logic [SLOTS_W-1:0] probes_r, probes_nxt;
  logic               out_valid_r, out_valid_nxt;

  // datapath
  logic [KEY_W-1:0]   key_r, key_nxt;
  logic [31:0]        h_r, h_nxt;
  logic [31:0]        k_r, k_nxt;
  logic [SLOTS_W-1:0] rem_r, rem_nxt;
  logic [SW-1:0]      res_cl_r, res_cl_nxt;
  logic               res_new_r, res_new_nxt;
  logic [CNT_W-1:0]   res_sz_r, res_sz_nxt;
  logic               res_full_r, res_full_nxt;
  logic               out_load;
  logic [CL_W-1:0]    out_cl_r;
  logic               out_new_r;
  logic [CNT_W-1:0]   out_sz_r;
  logic               out_full_r;

  logic [63:0]        keyx;
  logic [31:0]        word;
  logic [31:0]        mul_a, mul_b, mul_p;

  // memories
  logic [SE_W-1:0]    slot_mem [TABLE_SLOTS];
  logic [SE_W-1:0]    slot_q;
  logic               slot_we;
  logic [SW-1:0]      slot_wa;
  logic [SE_W-1:0]    slot_wd;
  logic [SW-1:0]      slot_ra;
  logic [CNT_W-1:0]   cnt_mem [TABLE_SLOTS];
  logic [CNT_W-1:0]   cnt_q;
  logic               cnt_we;
  logic [SW-1:0]      cnt_wa;
  logic [CNT_W-1:0]   cnt_wd;

  logic               sq_valid;
  logic [KEY_W-1:0]   sq_key;
  logic [SW-1:0]      sq_cl;
  logic [SW-1:0]      new_cl;

  assign sq_valid = slot_q[SE_W-1];
  assign sq_key   = slot_q[SW +: KEY_W];
  assign sq_cl    = slot_q[SW-1:0];
  assign new_cl   = SW'(ncl_r);
  assign slot_ra  = SW'(pos_r);

  always_comb begin
    if (slots_r == '0) begin
      eff = SLOTS_W'(1);
    end else if (32'(slots_r) > 32'(TABLE_SLOTS)) begin
      eff = SLOTS_W'(TABLE_SLOTS);
    end else begin
      eff = slots_r;
    end
  end

  assign keyx  = 64'(key_r);
  assign word  = word_r ? keyx[63:32] : keyx[31:0];
  assign mul_p = mul_a * mul_b;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    logic [31:0]        t;
    logic [31:0]        hd;
    logic [SLOTS_W-1:0] r;
    logic [SLOTS_W:0]   tr;
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    ncl_nxt       = ncl_r;
    hstep_nxt     = hstep_r;
    word_nxt      = word_r;
    dcnt_nxt      = dcnt_r;
    pos_nxt       = pos_r;
    probes_nxt    = probes_r;
    key_nxt       = key_r;
    h_nxt         = h_r;
    k_nxt         = k_r;
    rem_nxt       = rem_r;
    res_cl_nxt    = res_cl_r;
    res_new_nxt   = res_new_r;
    res_sz_nxt    = res_sz_r;
    res_full_nxt  = res_full_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_load      = 1'b0;
    mul_a         = h_r;
    mul_b         = MM_C1;
    slot_we       = 1'b0;
    slot_wa       = slot_ra;
    slot_wd       = '0;
    cnt_we        = 1'b0;
    cnt_wa        = res_cl_r;
    cnt_wd        = '0;
    t             = h_r;
    hd            = h_r;
    r             = rem_r;
    tr            = '0;
    case (state_r)
      S_CLR: begin
        slot_we = 1'b1;
        slot_wa = clr_r;
        if (clr_r == SW'(TABLE_SLOTS - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          clr_nxt = clr_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          key_nxt   = in_key[KEY_W-1:0];
          h_nxt     = seed_r;
          word_nxt  = 1'b0;
          hstep_nxt = 2'd0;
          state_nxt = S_HASH;
        end
      end
      S_HASH: begin
        case (hstep_r)
          2'd0: begin
            mul_a     = word;
            mul_b     = MM_C1;
            k_nxt     = mul_p;
            hstep_nxt = 2'd1;
          end
          2'd1: begin
            mul_a     = {k_r[16:0], k_r[31:17]};
            mul_b     = MM_C2;
            k_nxt     = mul_p;
            hstep_nxt = 2'd2;
          end
          default: begin
            t = h_r ^ k_r;
            if (32'(word_r) < NBLK) begin
              t = {t[18:0], t[31:19]};
              t = (t << 2) + t + MM_ADD;
            end
            h_nxt     = t;
            hstep_nxt = 2'd0;
            if (32'(word_r) == NW - 1) begin
              state_nxt = S_FIN;
            end else begin
              word_nxt = 1'b1;
            end
          end
        endcase
      end
      S_FIN: begin
        case (hstep_r)
          2'd0: begin
            t         = h_r ^ 32'(KEY_BYTES);
            mul_a     = t ^ (t >> 16);
            mul_b     = MM_F1;
            h_nxt     = mul_p;
            hstep_nxt = 2'd1;
          end
          2'd1: begin
            mul_a     = h_r ^ (h_r >> 13);
            mul_b     = MM_F2;
            h_nxt     = mul_p;
            hstep_nxt = 2'd2;
          end
          default: begin
            h_nxt     = h_r ^ (h_r >> 16);
            rem_nxt   = '0;
            dcnt_nxt  = '0;
            hstep_nxt = 2'd0;
            state_nxt = S_DIV;
          end
        endcase
      end
      S_DIV: begin
        // restoring remainder, four dividend bits per cycle
        for (int j = 0; j < 4; j++) begin
          tr = {r, hd[31]};
          hd = hd << 1;
          if (tr >= {1'b0, eff}) begin
            r = SLOTS_W'(tr - {1'b0, eff});
          end else begin
            r = tr[SLOTS_W-1:0];
          end
        end
        h_nxt    = hd;
        rem_nxt  = r;
        dcnt_nxt = dcnt_r + 1'b1;
        if (dcnt_r == 3'd7) begin
          pos_nxt    = r;
          probes_nxt = '0;
          state_nxt  = S_PRD;
        end
      end
      S_PRD: begin
        state_nxt = S_PCHK;
      end
      S_PCHK: begin
        if (!sq_valid) begin
          slot_we      = 1'b1;
          slot_wa      = slot_ra;
          slot_wd      = {1'b1, key_r, new_cl};
          cnt_we       = 1'b1;
          cnt_wa       = new_cl;
          cnt_wd       = CNT_W'(1);
          ncl_nxt      = ncl_r + 1'b1;
          res_cl_nxt   = new_cl;
          res_new_nxt  = 1'b1;
          res_sz_nxt   = CNT_W'(1);
          res_full_nxt = 1'b0;
          state_nxt    = S_OUT;
        end else if (sq_key == key_r) begin
          res_cl_nxt = sq_cl;
          state_nxt  = S_CRD;
        end else if (probes_r == eff - 1'b1) begin
          res_cl_nxt   = '0;
          res_new_nxt  = 1'b0;
          res_sz_nxt   = '0;
          res_full_nxt = 1'b1;
          state_nxt    = S_OUT;
        end else begin
          pos_nxt    = (pos_r == eff - 1'b1) ? '0 : pos_r + 1'b1;
          probes_nxt = probes_r + 1'b1;
          state_nxt  = S_PRD;
        end
      end
      S_CRD: begin
        // cnt_q holds the count of the hit cluster, read at the compare cycle
        cnt_we       = 1'b1;
        cnt_wa       = res_cl_r;
        cnt_wd       = (cnt_q == COUNT_MAX) ? cnt_q : cnt_q + 1'b1;
        res_sz_nxt   = cnt_wd;
        res_new_nxt  = 1'b0;
        res_full_nxt = 1'b0;
        state_nxt    = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      ncl_r       <= '0;
      hstep_r     <= '0;
      word_r      <= 1'b0;
      dcnt_r      <= '0;
      pos_r       <= '0;
      probes_r    <= '0;
      out_valid_r <= 1'b0;
      seed_r      <= '0;
      slots_r     <= SLOTS_RESET;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      ncl_r       <= ncl_nxt;
      hstep_r     <= hstep_nxt;
      word_r      <= word_nxt;
      dcnt_r      <= dcnt_nxt;
      pos_r       <= pos_nxt;
      probes_r    <= probes_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_idx)
          CFG_HASH_SEED:    seed_r  <= cfg_wdata;
          CFG_SLOTS_IN_USE: slots_r <= cfg_wdata[SLOTS_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    key_r      <= key_nxt;
    h_r        <= h_nxt;
    k_r        <= k_nxt;
    rem_r      <= rem_nxt;
    res_cl_r   <= res_cl_nxt;
    res_new_r  <= res_new_nxt;
    res_sz_r   <= res_sz_nxt;
    res_full_r <= res_full_nxt;
    if (out_load) begin
      out_cl_r   <= CL_W'(res_cl_r);
      out_new_r  <= res_new_r;
      out_sz_r   <= res_sz_r;
      out_full_r <= res_full_r;
    end
  end

  // slot table: valid, key, cluster
  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[slot_wa] <= slot_wd;
    end
    slot_q <= slot_mem[slot_ra];
  end

  // member counts, indexed by cluster
  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_wa] <= cnt_wd;
    end
    cnt_q <= cnt_mem[sq_cl];
  end

  assign out_valid        = out_valid_r;
  assign out_cluster_id   = out_cl_r;
  assign out_is_new       = out_new_r;
  assign out_cluster_size = out_sz_r;
  assign out_table_full   = out_full_r;

  a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_table_full |->
      out_cluster_id == '0 && out_cluster_size == '0 && !out_is_new)
    else $error("table_full word carries nonzero fields");

  a_new_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_new |-> out_cluster_size == CNT_W'(1) && !out_table_full)
    else $error("new cluster word without size one");

  a_probe_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_PCHK |-> probes_r < eff && pos_r < eff)
    else $error("probe walk beyond slots in use");

  a_hit_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_PCHK && sq_valid && sq_key == key_r |=> state_r == S_CRD)
    else $error("key hit did not update member count");

endmodule
